[src/rrmr_pkg.sv]
package rrmr_pkg;

  localparam int unsigned WordW = 32;
  localparam int unsigned WideW = 64;
  localparam int unsigned CntW  = 7;

  localparam logic OP_SET    = 1'b0;
  localparam logic OP_MULDIV = 1'b1;

  localparam logic [WideW-1:0] TOP_MASK = 64'hffff_ffff_8000_0000;

  typedef struct packed {
    logic start;
    logic op;
  } cmd_t;

  typedef struct packed {
    logic done;
  } stat_t;

endpackage

[src/rrmr_datapath.sv]
module rrmr_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  rrmr_pkg::cmd_t                cmd,
  input  logic [rrmr_pkg::WordW-1:0]    a_in,
  input  logic [rrmr_pkg::WordW-1:0]    b_in,
  output rrmr_pkg::stat_t               stat,
  output logic [rrmr_pkg::WordW-1:0]    num,
  output logic [rrmr_pkg::WordW-1:0]    den
);

  // phases of the iterative datapath
  typedef enum logic [3:0] {
    P_IDLE, P_MUL, P_GCD_INIT, P_GCD, P_DIV_INIT, P_DIV, P_SCAN, P_RND, P_DONE
  } phase_t;

  phase_t                      phase;
  logic                        setmode;   // current pass reduces a set pair or a rescaled pair
  logic [rrmr_pkg::WideW-1:0]  n, d;      // working pair
  logic [rrmr_pkg::WideW-1:0]  gx, gy;    // gcd operands
  logic [rrmr_pkg::WideW-1:0]  rem;       // restoring-division remainder
  logic [rrmr_pkg::WideW-1:0]  quo;       // quotient shifting in
  logic [rrmr_pkg::WideW-1:0]  dvd;       // dividend shifting out
  logic [rrmr_pkg::CntW-1:0]   cnt;
  logic                        div_sel;   // 0: dividing for gcd, 1: dividing n/d by g
  logic                        div_den;   // reducing den second
  logic [rrmr_pkg::WideW-1:0]  acc;
  logic [rrmr_pkg::CntW-1:0]   u;
  logic [rrmr_pkg::WideW-1:0]  rem_sh, rem_sub;
  logic                        ge;

  assign rem_sh  = {rem[rrmr_pkg::WideW-2:0], dvd[rrmr_pkg::WideW-1]};
  assign ge      = (rem[rrmr_pkg::WideW-1] == 1'b1) || (rem_sh >= gy);
  assign rem_sub = rem_sh - gy;

  assign stat.done = (phase == P_DONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= P_IDLE;
      num   <= '0;
      den   <= {{(rrmr_pkg::WordW-1){1'b0}}, 1'b1};
    end else begin
      case (phase)
        P_IDLE: begin
          if (cmd.start) begin
            if (cmd.op == rrmr_pkg::OP_SET) begin
              n       <= {32'd0, a_in};
              d       <= {32'd0, b_in};
              setmode <= 1'b1;
              phase   <= P_GCD_INIT;
            end else begin
              setmode <= 1'b0;
              phase   <= P_MUL;
            end
          end
        end
        P_MUL: begin
          n     <= {32'd0, num} * {32'd0, a_in};
          d     <= {32'd0, den} * {32'd0, b_in};
          phase <= P_GCD_INIT;
        end
        P_GCD_INIT: begin
          if (setmode && (n == '0 || d == '0)) begin
            num   <= '0;
            den   <= 32'd1;
            phase <= P_DONE;
          end else if (n == '0 && d == '0) begin
            num   <= '0;
            den   <= 32'd1;
            phase <= P_DONE;
          end else begin
            gx    <= n;
            gy    <= d;
            phase <= P_GCD;
          end
        end
        P_GCD: begin
          // gcd in gx once gy hits zero; else start gx % gy
          if (gy == '0) begin
            gy      <= gx;
            dvd     <= n;
            rem     <= '0;
            quo     <= '0;
            cnt     <= '0;
            div_sel <= 1'b1;
            div_den <= 1'b0;
            phase   <= P_DIV;
          end else begin
            dvd     <= gx;
            rem     <= '0;
            quo     <= '0;
            cnt     <= '0;
            div_sel <= 1'b0;
            phase   <= P_DIV;
          end
        end
        P_DIV: begin
          // one quotient bit a cycle
          rem <= ge ? rem_sub : rem_sh;
          quo <= {quo[rrmr_pkg::WideW-2:0], ge};
          dvd <= {dvd[rrmr_pkg::WideW-2:0], 1'b0};
          cnt <= cnt + 1'b1;
          if (cnt == rrmr_pkg::CntW'(rrmr_pkg::WideW - 1)) phase <= P_DIV_INIT;
        end
        P_DIV_INIT: begin
          if (!div_sel) begin
            gx    <= gy;
            gy    <= rem;
            phase <= P_GCD;
          end else if (!div_den) begin
            n       <= quo;
            dvd     <= d;
            rem     <= '0;
            quo     <= '0;
            cnt     <= '0;
            div_den <= 1'b1;
            phase   <= P_DIV;
          end else begin
            d     <= quo;
            acc   <= n | quo;
            u     <= '0;
            phase <= setmode ? P_RND : P_SCAN;
          end
        end
        P_SCAN: begin
          if ((acc & rrmr_pkg::TOP_MASK) != '0) begin
            acc <= acc >> 1;
            u   <= u + 1'b1;
          end else begin
            phase <= P_RND;
          end
        end
        P_RND: begin
          if (u == '0) begin
            num   <= n[rrmr_pkg::WordW-1:0];
            den   <= d[rrmr_pkg::WordW-1:0];
            phase <= P_DONE;
          end else begin
            n       <= {32'd0, 32'((n + (64'd1 << (u - 1'b1))) >> u)};
            d       <= {32'd0, 32'((d + (64'd1 << (u - 1'b1))) >> u)};
            setmode <= 1'b1;
            phase   <= P_GCD_INIT;
          end
        end
        P_DONE: phase <= P_IDLE;
        default: phase <= P_IDLE;
      endcase
    end
  end

endmodule

[src/rrmr_ctrl.sv]
module rrmr_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic            in_op,
  output logic            in_stall,
  input  logic            out_stall,
  output logic            out_valid,
  output rrmr_pkg::cmd_t  cmd,
  input  rrmr_pkg::stat_t stat
);

  typedef enum logic [1:0] {S_IDLE, S_BUSY, S_OUT} state_t;
  state_t state;

  assign in_stall  = (state != S_IDLE);
  assign cmd.start = (state == S_IDLE) && in_valid;
  assign cmd.op    = in_op;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: if (in_valid) state <= S_BUSY;
        S_BUSY: if (stat.done) begin
          state     <= S_OUT;
          out_valid <= 1'b1;
        end
        S_OUT: if (!out_stall) begin
          state     <= S_IDLE;
          out_valid <= 1'b0;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[src/rational_rate_muldiv_reduce.sv]
// Reduced frame-rate fraction keeper.
// Input channel: in_valid/in_stall with opcode, operand_a, operand_b.
//   opcode 0 stores operand_a/operand_b in lowest terms (0/1 if either is 0);
//   opcode 1 multiplies the stored rate by operand_a/operand_b, reduces it,
//   and rescales with rounding when the result does not fit in 31 bits.
// Output channel: out_valid/out_stall with rate_num, rate_den, one transaction
//   per input transaction, giving the stored fraction after it.
// One transaction at a time. Run time is set by the Euclidean GCD, each
//   remainder taken by a bit-serial divider, plus two more divisions to
//   reduce the pair, plus a rescale scan for opcode 1, and a second pass after a rescale.
// Reset sets the rate to 0/1 and empties the block.
// While out_stall holds, the result waits in its register and in_stall stays
//   high; the next input transaction is taken the cycle after delivery.
module rational_rate_muldiv_reduce (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        opcode,
  input  logic [31:0] operand_a,
  input  logic [31:0] operand_b,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] rate_num,
  output logic [31:0] rate_den
);

  rrmr_pkg::cmd_t  cmd;
  rrmr_pkg::stat_t stat;
  logic [31:0]     a_q, b_q;

  // operands held for the multiply step
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      a_q <= operand_a;
      b_q <= operand_b;
    end
  end

  rrmr_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_op(opcode), .in_stall,
    .out_stall, .out_valid, .cmd, .stat
  );

  rrmr_datapath u_dp (
    .clk, .rst, .cmd,
    .a_in(cmd.start ? operand_a : a_q),
    .b_in(cmd.start ? operand_b : b_q),
    .stat, .num(rate_num), .den(rate_den)
  );

  // no new transaction while a result waits
  a_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall) else $error("accept while result pending");

  // result holds while stalled
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> ($stable(rate_num) && $stable(rate_den)))
    else $error("result changed under stall");

  // done always raises valid
  a_done: assert property (@(posedge clk) disable iff (rst)
    stat.done |=> out_valid) else $error("done lost");

endmodule
